// File: sv/partition_fit_allocator_defines.svh
// ----------------------------------------------------------------------------
// Partition fit allocator assertion macros
// Shared assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define PFA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pfa_pkg.sv
// ----------------------------------------------------------------------------
// Partition fit allocator package
// Command, policy and status codes, payload and cell control types.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_INDEX = 2'd3;

  // Owner stored for a free section
  localparam logic [7:0] OWNER_FREE = 8'd0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_RESP
  } pfa_state_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_ROTATE,
    CM_LOAD,
    CM_TAKE,
    CM_INSERT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t  mode;
    logic [7:0]  target;
    logic [7:0]  owner;
    logic        busy;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  fit_policy;
    logic [15:0] request_size;
    logic [7:0]  owner_id;
    logic        load_free;
    logic [3:0]  read_index;
  } pfa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  placed_index;
    logic [15:0] entry_size;
    logic [7:0]  entry_owner;
    logic        entry_occupied;
    logic [4:0]  section_total;
  } pfa_out_t;

endpackage

`default_nettype wire

// File: sv/pfa_cell.sv
// ----------------------------------------------------------------------------
// Partition fit allocator cell
// Holds one table entry; loads or takes it in place, rotates toward the head, shifts for an insert.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_cell import pfa_pkg::*; #(
  parameter int SIZE_BITS = 16,
  parameter int IDX       = 0
) (
  input  wire                  clk,
  input  wire cell_ctrl_t      ctrl,
  input  wire [SIZE_BITS-1:0]  need,
  input  wire [SIZE_BITS-1:0]  left_size,
  input  wire [7:0]            left_owner,
  input  wire                  left_busy,
  input  wire [SIZE_BITS-1:0]  right_size,
  input  wire [7:0]            right_owner,
  input  wire                  right_busy,
  output logic [SIZE_BITS-1:0] q_size,
  output logic [7:0]           q_owner,
  output logic                 q_busy
);

  localparam logic [8:0] MY_IDX = 9'(IDX);

  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic [7:0]           owner_r, owner_nxt;
  logic                 busy_r, busy_nxt;
  logic [8:0]           tgt;
  logic [8:0]           tgt_p1;

  assign tgt    = {1'b0, ctrl.target};
  assign tgt_p1 = tgt + 9'd1;

  always_comb begin
    size_nxt  = size_r;
    owner_nxt = owner_r;
    busy_nxt  = busy_r;
    case (ctrl.mode)
      CM_ROTATE: begin
        size_nxt  = right_size;
        owner_nxt = right_owner;
        busy_nxt  = right_busy;
      end
      CM_LOAD: begin
        if (MY_IDX == tgt) begin
          size_nxt  = need;
          owner_nxt = ctrl.owner;
          busy_nxt  = ctrl.busy;
        end
      end
      CM_TAKE: begin
        if (MY_IDX == tgt) begin
          owner_nxt = ctrl.owner;
          busy_nxt  = 1'b1;
        end
      end
      CM_INSERT: begin
        if (MY_IDX == tgt) begin
          size_nxt  = need;
          owner_nxt = ctrl.owner;
          busy_nxt  = 1'b1;
        end else if (MY_IDX == tgt_p1) begin
          // split remainder of the chosen section
          size_nxt  = left_size - need;
          owner_nxt = left_owner;
          busy_nxt  = left_busy;
        end else if (MY_IDX > tgt_p1) begin
          size_nxt  = left_size;
          owner_nxt = left_owner;
          busy_nxt  = left_busy;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    owner_r <= owner_nxt;
    busy_r  <= busy_nxt;
  end

  assign q_size  = size_r;
  assign q_owner = owner_r;
  assign q_busy  = busy_r;

endmodule

`default_nettype wire

// File: sv/partition_fit_allocator.sv
// Load, read and unused commands go from the item register through execute and respond to the output register.
// Allocate scans first: the cell chain rotates once through the head before execute.
// Throughput: one item at a time; next item taken once the result is in the output register.
// Reset: synchronous active-low rst_n empties the table and clears control state.
// Table entries are not cleared; entries past the section count are never observed.
// ----------------------------------------------------------------------------
// Partition fit allocator
// Ordered section table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "partition_fit_allocator_defines.svh"

module partition_fit_allocator import pfa_pkg::*; #(
  parameter int MAX_SECTIONS = 16,
  parameter int SIZE_BITS    = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_stall,
  input  wire pfa_in_t in_data,
  output logic         out_valid,
  input  wire          out_stall,
  output pfa_out_t     out_data
);

  localparam int IDX_W = $clog2(MAX_SECTIONS);
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
  localparam int RX_W  = (IDX_W > 4) ? IDX_W : 4;
  localparam int NW    = (SIZE_BITS > 16) ? SIZE_BITS : 16;
  localparam int TW    = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SECTIONS - 1);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_SECTIONS);

  pfa_state_t           state_r, state_nxt;
  pfa_in_t              item_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     scan_r, scan_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] pick_size_r, pick_size_nxt;
  pfa_out_t             res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pfa_out_t             out_data_r, out_data_nxt;
  cell_ctrl_t           ctrl;

  logic [SIZE_BITS-1:0] c_size  [MAX_SECTIONS];
  logic [7:0]           c_owner [MAX_SECTIONS];
  logic                 c_busy  [MAX_SECTIONS];

  logic [NW-1:0]        need_w;
  logic [SIZE_BITS-1:0] need;
  logic [RX_W-1:0]      ridx_w;
  logic [IDX_W-1:0]     ridx;
  logic [NW-1:0]        rd_size_w;
  logic                 head_fits;
  logic [IDX_W-1:0]     placed_idx;
  logic [RX_W-1:0]      placed_w;
  logic [TW-1:0]        total_w;

  assign need_w    = NW'(item_r.request_size);
  assign need      = need_w[SIZE_BITS-1:0];
  assign ridx_w    = RX_W'(item_r.read_index);
  assign ridx      = ridx_w[IDX_W-1:0];
  assign rd_size_w = NW'(c_size[ridx]);
  assign placed_w  = RX_W'(placed_idx);
  assign total_w   = TW'(count_nxt);
  assign head_fits = (CNT_W'(scan_r) < count_r) && !c_busy[0] && (c_size[0] >= need);

  for (genvar k = 0; k < MAX_SECTIONS; k++) begin : g_cell
    pfa_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDX       (k)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .need        (need),
      .left_size   (c_size[(k + MAX_SECTIONS - 1) % MAX_SECTIONS]),
      .left_owner  (c_owner[(k + MAX_SECTIONS - 1) % MAX_SECTIONS]),
      .left_busy   (c_busy[(k + MAX_SECTIONS - 1) % MAX_SECTIONS]),
      .right_size  (c_size[(k + 1) % MAX_SECTIONS]),
      .right_owner (c_owner[(k + 1) % MAX_SECTIONS]),
      .right_busy  (c_busy[(k + 1) % MAX_SECTIONS]),
      .q_size      (c_size[k]),
      .q_owner     (c_owner[k]),
      .q_busy      (c_busy[k])
    );
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    pick_size_nxt = pick_size_r;
    res_nxt       = res_r;
    placed_idx    = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ctrl.mode     = CM_HOLD;
    ctrl.target   = 8'(pick_r);
    ctrl.owner    = item_r.owner_id;
    ctrl.busy     = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.command == CMD_ALLOC) ? S_SCAN : S_EXEC;
          scan_nxt  = '0;
          found_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        // entry scan_r sits at the head cell this cycle
        ctrl.mode = CM_ROTATE;
        if (head_fits) begin
          if (!found_r) begin
            found_nxt     = 1'b1;
            pick_nxt      = scan_r;
            pick_size_nxt = c_size[0];
          end else if (item_r.fit_policy == POL_BEST && c_size[0] < pick_size_r) begin
            pick_nxt      = scan_r;
            pick_size_nxt = c_size[0];
          end else if (item_r.fit_policy == POL_WORST && c_size[0] > pick_size_r) begin
            pick_nxt      = scan_r;
            pick_size_nxt = c_size[0];
          end
        end
        scan_nxt = scan_r + 1'b1;
        if (scan_r == LAST_IDX) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt = '0;
        case (item_r.command)
          CMD_LOAD: begin
            if (count_r >= MAX_CNT) begin
              res_nxt.status = ST_FULL;
            end else begin
              ctrl.mode   = CM_LOAD;
              ctrl.target = 8'(count_r);
              ctrl.owner  = item_r.load_free ? OWNER_FREE : item_r.owner_id;
              ctrl.busy   = !item_r.load_free;
              placed_idx  = count_r[IDX_W-1:0];
              count_nxt   = count_r + 1'b1;
            end
          end
          CMD_ALLOC: begin
            if (!found_r) begin
              res_nxt.status = ST_NOFIT;
            end else if (pick_size_r == need) begin
              ctrl.mode  = CM_TAKE;
              placed_idx = pick_r;
            end else if (count_r >= MAX_CNT) begin
              res_nxt.status = ST_FULL;
            end else begin
              ctrl.mode  = CM_INSERT;
              placed_idx = pick_r;
              count_nxt  = count_r + 1'b1;
            end
          end
          CMD_READ: begin
            if (int'(item_r.read_index) >= int'(count_r)) begin
              res_nxt.status = ST_INDEX;
            end else begin
              placed_idx             = ridx;
              res_nxt.entry_size     = rd_size_w[15:0];
              res_nxt.entry_owner    = c_owner[ridx];
              res_nxt.entry_occupied = c_busy[ridx];
            end
          end
          default: begin
          end
        endcase
        res_nxt.placed_index  = placed_w[3:0];
        res_nxt.section_total = total_w[4:0];
        state_nxt             = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
    scan_r      <= scan_nxt;
    pick_r      <= pick_nxt;
    pick_size_r <= pick_size_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  `PFA_ASSERT_ALWAYS(a_count_bound, count_r <= MAX_CNT, "section count above table depth")
  `PFA_ASSERT_NEXT(a_scan_done, state_r == S_SCAN && scan_r == LAST_IDX, state_r == S_EXEC, "scan did not end after one full rotation")
  `PFA_ASSERT_NEXT(a_count_step, state_r != S_EXEC, count_r == $past(count_r), "section count changed outside execute")
  `PFA_ASSERT_NEXT(a_resp_out, state_r == S_RESP && (!out_valid_r || !out_stall), out_valid_r && state_r == S_IDLE, "result not moved to output register")

endmodule

`default_nettype wire
